// ----- hdl/smoothed_biquad_cascade_top_macros.svh -----
// assertion macros shared by the biquad cascade modules
`ifndef SMOOTHED_BIQUAD_CASCADE_TOP_MACROS_SVH
`define SMOOTHED_BIQUAD_CASCADE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SBQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbq assertion failed");
`define SBQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbq assertion failed");
`else
`define SBQ_ASSERT_IMP(label, ante, cons)
`define SBQ_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- hdl/sbq_pkg.sv -----
// shared types and constants of the smoothed biquad cascade
package sbq_pkg;

  localparam int COEF_BITS   = 24;
  localparam int DELAY_BITS  = 40;
  localparam int DELAY_EXTRA = 8;
  localparam int SLOTS       = 5;
  localparam int RATE_BITS   = 16;
  localparam int RATE_FRAC   = 16;
  localparam int IDX_BITS    = 5;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_RATE   = 1'b1;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_STEP   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH0     = 7'b0000010,
    PH1     = 7'b0000100,
    PH2     = 7'b0001000,
    PH3     = 7'b0010000,
    PH4     = 7'b0100000,
    PH5     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic                        valid;
    op_t                         op;
    logic                        ch;
    logic                        act;
    logic                        clip;
    logic [IDX_BITS-1:0]         idx;
    logic signed [COEF_BITS-1:0] coef;
  } tok_t;

  typedef struct packed {
    logic active;
    logic done;
  } cell_stat_t;

endpackage

// ----- hdl/smoothed_biquad_cascade_top.sv -----
// Smoothed biquad cascade: a row of stage cells, one item in flight at a time.
// A new request is taken only once the last cell has finished its six-phase sequence of
//   the shared multiplier in each cell and the result register is empty; each cell hands
//   a request on to the next cell from its phase PH1, before its own sequence ends.
// Reset (rst, synchronous): coefficients to passthrough, delays to zero, enable 1,
//   smooth_rate 6554; the block is ready in the cycle after reset.
`include "smoothed_biquad_cascade_top_macros.svh"
module smoothed_biquad_cascade_top
  import sbq_pkg::*;
#(
  parameter int CHANNELS       = 2,
  parameter int STAGES         = 4,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic                                    cfg_index,
  input  logic [RATE_BITS-1:0]                    cfg_data,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // channel, coef_index, sample, coef_value
  input  logic [((SAMPLE_BITS+30+7)/8)*8-1:0]     s_tdata,
  // opcode
  input  logic [1:0]                              s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // out_sample, out_channel
  output logic [((SAMPLE_BITS+1+7)/8)*8-1:0]      m_tdata,
  // clipped
  output logic [0:0]                              m_tuser
);

  localparam int OUT_W  = ((SAMPLE_BITS + 1 + 7) / 8) * 8;
  localparam int SMP_LO = 1 + IDX_BITS;
  localparam int CF_LO  = SMP_LO + SAMPLE_BITS;

  logic                 enable;
  logic [RATE_BITS-1:0] rate;
  logic                 inflight;
  logic                 accept;
  logic                 in_ch;
  logic                 ch_ok;

  tok_t                          tok [STAGES+1];
  logic signed [SAMPLE_BITS-1:0] xs  [STAGES+1];
  cell_stat_t                    stat [STAGES];

  logic                          res_valid;
  logic signed [SAMPLE_BITS-1:0] res_sample;
  logic                          res_ch;
  logic                          res_clip;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_ch;
  logic                          out_clip;
  logic                          new_res;
  logic                          move;

  assign in_ch    = s_tdata[0];
  assign ch_ok    = int'(in_ch) < CHANNELS;
  assign s_tready = !inflight && !res_valid;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
      rate   <= RATE_BITS'(6554);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: enable <= cfg_data[0];
        REG_RATE:   rate   <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0]   <= '0;
      inflight <= 1'b0;
    end else begin
      if (accept) begin
        tok[0].valid <= 1'b1;
        tok[0].op    <= op_t'(s_tuser);
        tok[0].ch    <= in_ch;
        tok[0].act   <= enable && ch_ok;
        tok[0].clip  <= 1'b0;
        tok[0].idx   <= s_tdata[IDX_BITS:1];
        tok[0].coef  <= s_tdata[CF_LO+COEF_BITS-1:CF_LO];
        xs[0]        <= s_tdata[CF_LO-1:SMP_LO];
        inflight     <= 1'b1;
      end else begin
        tok[0].valid <= 1'b0;
        if (stat[STAGES-1].done) begin
          inflight <= 1'b0;
        end
      end
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    sbq_cell #(
      .CHANNELS       (CHANNELS),
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .STAGE_ID       (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[g]),
      .x_in    (xs[g]),
      .rate    (rate),
      .tok_out (tok[g+1]),
      .y_out   (xs[g+1]),
      .stat    (stat[g])
    );
  end

  assign new_res = tok[STAGES].valid && (tok[STAGES].op == OP_SAMPLE);
  assign move    = res_valid && (!m_tvalid || m_tready);

  // result register plus output register, so a waiting result never stalls the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (move) begin
        out_sample <= res_sample;
        out_ch     <= res_ch;
        out_clip   <= res_clip;
        m_tvalid   <= 1'b1;
        res_valid  <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (new_res) begin
        res_sample <= xs[STAGES];
        res_ch     <= tok[STAGES].ch;
        res_clip   <= tok[STAGES].clip;
        res_valid  <= 1'b1;
      end
    end
  end

  assign m_tdata = OUT_W'({out_ch, out_sample});
  assign m_tuser = out_clip;

  `SBQ_ASSERT_NXT(a_one_in_flight, accept, !s_tready)
  `SBQ_ASSERT_IMP(a_result_slot_free, new_res, !res_valid)
  `SBQ_ASSERT_IMP(a_done_while_inflight, stat[STAGES-1].done, inflight)
  `SBQ_ASSERT_IMP(a_ready_chain_idle, s_tready, !stat[STAGES-1].active && !tok[0].valid)

endmodule

// ----- hdl/sbq_cell.sv -----
// one biquad stage cell: coefficients, delays and a shared multiplier
`include "smoothed_biquad_cascade_top_macros.svh"
module sbq_cell
  import sbq_pkg::*;
#(
  parameter int CHANNELS       = 2,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 20,
  parameter int STAGE_ID       = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tok_t                          tok_in,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  input  logic [RATE_BITS-1:0]          rate,
  output tok_t                          tok_out,
  output logic signed [SAMPLE_BITS-1:0] y_out,
  output cell_stat_t                    stat
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW   = COEF_BITS + 1;
  localparam int BW   = SAMPLE_BITS + 1;
  localparam int PW   = AW + BW;
  localparam int WW   = PW + 2;
  localparam int SH   = COEF_FRAC_BITS - DELAY_EXTRA;
  localparam int BASE = STAGE_ID * SLOTS;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE =
    (COEF_FRAC_BITS >= COEF_BITS - 1) ? COEF_BITS'((1 << (COEF_BITS - 1)) - 1)
                                      : COEF_BITS'(1 << COEF_FRAC_BITS);
  localparam logic signed [WW-1:0] HALF_SH = WW'(1) << (SH - 1);
  localparam logic signed [WW-1:0] HALF_EX = WW'(1) << (DELAY_EXTRA - 1);
  localparam logic signed [WW-1:0] HALF_RT = WW'(1) << (RATE_FRAC - 1);
  localparam logic signed [WW-1:0] Y_HI = (WW'(1) << (SAMPLE_BITS - 1)) - WW'(1);
  localparam logic signed [WW-1:0] Y_LO = ~Y_HI;
  localparam logic signed [WW-1:0] D_HI = (WW'(1) << (DELAY_BITS - 1)) - WW'(1);
  localparam logic signed [WW-1:0] D_LO = ~D_HI;
  localparam logic signed [WW-1:0] C_HI = (WW'(1) << (COEF_BITS - 1)) - WW'(1);
  localparam logic signed [WW-1:0] C_LO = ~C_HI;

  logic signed [COEF_BITS-1:0]  tgt [SLOTS];
  logic signed [COEF_BITS-1:0]  smc [CHANNELS][SLOTS];
  logic signed [DELAY_BITS-1:0] z1 [CHANNELS];
  logic signed [DELAY_BITS-1:0] z2 [CHANNELS];

  phase_t                        ph;
  tok_t                          cur;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] y;
  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          p_hold;
  logic signed [WW-1:0]          acc;
  logic signed [COEF_BITS-1:0]   s_hold;

  logic [CH_W-1:0]               chi;
  logic [2:0]                    rslot;
  logic signed [COEF_BITS-1:0]   coef_rd;
  logic signed [COEF_BITS-1:0]   tgt_rd;
  logic signed [AW-1:0]          ma;
  logic signed [BW-1:0]          mb;
  logic signed [PW-1:0]          prod_next;
  logic signed [WW-1:0]          yq;
  logic signed [SAMPLE_BITS-1:0] y_val;
  logic                          hit_val;
  logic signed [WW-1:0]          n1;
  logic signed [WW-1:0]          n2;
  logic signed [WW-1:0]          d2;
  logic signed [DELAY_BITS-1:0]  n1_sat;
  logic signed [DELAY_BITS-1:0]  n2_sat;
  logic signed [WW-1:0]          sv;
  logic signed [COEF_BITS-1:0]   sv_sat;
  logic [IDX_BITS:0]             idx_ext;
  logic                          idx_hit;
  logic [2:0]                    lslot;
  logic                          is_step;
  tok_t                          tok_nx;

  assign chi     = CH_W'(cur.ch);
  assign is_step = (cur.op == OP_STEP);
  assign idx_ext = {1'b0, cur.idx};
  assign idx_hit = (idx_ext >= (IDX_BITS + 1)'(BASE)) &&
                   (idx_ext < (IDX_BITS + 1)'(BASE + SLOTS));
  assign lslot   = 3'(idx_ext - (IDX_BITS + 1)'(BASE));

  // filter phases walk b0 b1 a1 b2 a2, smoothing walks the slots in order
  always_comb begin
    case (ph)
      PH0:     rslot = SLOT_B0;
      PH1:     rslot = SLOT_B1;
      PH2:     rslot = is_step ? SLOT_B2 : SLOT_A1;
      PH3:     rslot = is_step ? SLOT_A1 : SLOT_B2;
      PH4:     rslot = SLOT_A2;
      default: rslot = SLOT_B0;
    endcase
  end

  assign coef_rd = smc[chi][rslot];
  assign tgt_rd  = tgt[rslot];

  always_comb begin
    if (is_step) begin
      ma = AW'(tgt_rd) - AW'(coef_rd);
      mb = BW'(signed'({1'b0, rate}));
    end else begin
      ma = AW'(coef_rd);
      mb = (ph == PH2 || ph == PH4) ? BW'(y) : BW'(x);
    end
  end

  assign prod_next = ma * mb;

  // stage output from b0*x and the first delay
  always_comb begin
    logic signed [WW-1:0] yw;
    yw = ((WW'(prod) + HALF_SH) >>> SH) + WW'(z1[chi]);
    yq = (yw + HALF_EX) >>> DELAY_EXTRA;
    hit_val = 1'b0;
    if (cur.op != OP_SAMPLE || !cur.act) begin
      y_val = x;
    end else if (yq > Y_HI) begin
      y_val   = Y_HI[SAMPLE_BITS-1:0];
      hit_val = 1'b1;
    end else if (yq < Y_LO) begin
      y_val   = Y_LO[SAMPLE_BITS-1:0];
      hit_val = 1'b1;
    end else begin
      y_val = yq[SAMPLE_BITS-1:0];
    end
  end

  // request handed to the next cell
  always_comb begin
    tok_nx       = cur;
    tok_nx.valid = 1'b1;
    tok_nx.clip  = cur.clip | hit_val;
  end

  // delay updates
  always_comb begin
    d2 = WW'(p_hold) - WW'(prod);
    n1 = ((acc + HALF_SH) >>> SH) + WW'(z2[chi]);
    n2 = (d2 + HALF_SH) >>> SH;
    if (n1 > D_HI)      n1_sat = D_HI[DELAY_BITS-1:0];
    else if (n1 < D_LO) n1_sat = D_LO[DELAY_BITS-1:0];
    else                n1_sat = n1[DELAY_BITS-1:0];
    if (n2 > D_HI)      n2_sat = D_HI[DELAY_BITS-1:0];
    else if (n2 < D_LO) n2_sat = D_LO[DELAY_BITS-1:0];
    else                n2_sat = n2[DELAY_BITS-1:0];
  end

  // smoothed coefficient from the held value and rate*(target - smoothed)
  always_comb begin
    sv = WW'(s_hold) + ((WW'(prod) + HALF_RT) >>> RATE_FRAC);
    if (sv > C_HI)      sv_sat = C_HI[COEF_BITS-1:0];
    else if (sv < C_LO) sv_sat = C_LO[COEF_BITS-1:0];
    else                sv_sat = sv[COEF_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph      <= PH_IDLE;
      tok_out <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        tgt[k] <= (k == 0) ? COEF_ONE : '0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < SLOTS; k++) begin
          smc[c][k] <= (k == 0) ? COEF_ONE : '0;
        end
        z1[c] <= '0;
        z2[c] <= '0;
      end
    end else begin
      if (ph == PH1) begin
        tok_out <= tok_nx;
      end else begin
        tok_out.valid <= 1'b0;
      end
      case (ph)
        PH_IDLE: begin
          if (tok_in.valid) begin
            cur <= tok_in;
            x   <= x_in;
            ph  <= PH0;
          end
        end
        PH0: begin
          prod   <= prod_next;
          s_hold <= coef_rd;
          if (cur.op == OP_LOAD && idx_hit) begin
            tgt[lslot] <= cur.coef;
          end
          if (cur.op == OP_CLEAR) begin
            for (int c = 0; c < CHANNELS; c++) begin
              for (int k = 0; k < SLOTS; k++) begin
                smc[c][k] <= (k == 0) ? COEF_ONE : '0;
              end
              z1[c] <= '0;
              z2[c] <= '0;
            end
          end
          ph <= PH1;
        end
        PH1: begin
          prod   <= prod_next;
          s_hold <= coef_rd;
          if (is_step && cur.act) smc[chi][SLOT_B0] <= sv_sat;
          y     <= y_val;
          y_out <= y_val;
          ph    <= PH2;
        end
        PH2: begin
          prod   <= prod_next;
          s_hold <= coef_rd;
          p_hold <= prod;
          if (is_step && cur.act) smc[chi][SLOT_B1] <= sv_sat;
          ph <= PH3;
        end
        PH3: begin
          prod   <= prod_next;
          s_hold <= coef_rd;
          acc    <= WW'(p_hold) - WW'(prod);
          if (is_step && cur.act) smc[chi][SLOT_B2] <= sv_sat;
          ph <= PH4;
        end
        PH4: begin
          prod   <= prod_next;
          s_hold <= coef_rd;
          p_hold <= prod;
          if (is_step && cur.act) smc[chi][SLOT_A1] <= sv_sat;
          ph <= PH5;
        end
        PH5: begin
          if (is_step && cur.act) smc[chi][SLOT_A2] <= sv_sat;
          if (cur.op == OP_SAMPLE && cur.act) begin
            z1[chi] <= n1_sat;
            z2[chi] <= n2_sat;
          end
          ph <= PH_IDLE;
        end
        default: ph <= PH_IDLE;
      endcase
    end
  end

  assign stat.active = (ph != PH_IDLE);
  assign stat.done   = (ph == PH5);

  `SBQ_ASSERT_IMP(a_cell_free_on_arrival, tok_in.valid, ph == PH_IDLE)
  `SBQ_ASSERT_NXT(a_cell_hands_on, ph == PH1, tok_out.valid)
  `SBQ_ASSERT_NXT(a_cell_done_idle, stat.done, ph == PH_IDLE && !tok_out.valid)

endmodule

// ----- bench/tb.sv -----
// self-checking bench for the smoothed biquad cascade
`timescale 1ns / 1ps
import sbq_pkg::*;

typedef struct {
  logic [23:0] smp;
  logic        ch;
  logic        clip;
} filt_result_t;

class biquad_scoreboard;
  longint       target[20];
  longint       smooth[2][20];
  longint       dly[2][4][2];
  bit           en;
  longint       rate;
  filt_result_t expected_q[$];
  int           errors;

  function new();
    for (int k = 0; k < 20; k++) target[k] = (k % SLOTS == 0) ? (64'sd1 <<< 20) : 0;
    clear_state();
    en = 1;
    rate = 6554;
    errors = 0;
  endfunction

  function void clear_state();
    for (int c = 0; c < 2; c++) begin
      for (int k = 0; k < 20; k++) smooth[c][k] = (k % SLOTS == 0) ? (64'sd1 <<< 20) : 0;
      for (int s = 0; s < 4; s++) begin
        dly[c][s][0] = 0;
        dly[c][s][1] = 0;
      end
    end
  endfunction

  // round half up, then floor
  function longint rnd(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function longint clamp(longint v, int bits, inout bit hit);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) begin
      hit = 1;
      return hi;
    end
    if (v < -hi - 1) begin
      hit = 1;
      return -hi - 1;
    end
    return v;
  endfunction

  function void write_reg(logic idx, logic [15:0] v);
    if (idx == REG_ENABLE) en = v[0];
    else rate = v;
  endfunction

  function void note_request(op_t op, logic ch, logic [4:0] idx, logic [23:0] smp,
                             logic [23:0] cv);
    longint x, y, yw, d, n1, n2;
    bit clip, dummy;
    filt_result_t r;
    case (op)
      OP_LOAD: begin
        if (idx < 20) target[idx] = longint'($signed(cv));
      end
      OP_STEP: begin
        if (en) begin
          for (int k = 0; k < 20; k++) begin
            d = rate * (target[k] - smooth[ch][k]);
            smooth[ch][k] = clamp(smooth[ch][k] + rnd(d, RATE_FRAC), COEF_BITS, dummy);
          end
        end
      end
      OP_CLEAR: clear_state();
      default: begin
        x = longint'($signed(smp));
        clip = 0;
        if (en) begin
          for (int s = 0; s < 4; s++) begin
            yw = rnd(smooth[ch][s*5+SLOT_B0] * x, 12) + dly[ch][s][0];
            y = clamp(rnd(yw, DELAY_EXTRA), 24, clip);
            n1 = clamp(rnd(smooth[ch][s*5+SLOT_B1] * x - smooth[ch][s*5+SLOT_A1] * y, 12)
                       + dly[ch][s][1], DELAY_BITS, dummy);
            n2 = clamp(rnd(smooth[ch][s*5+SLOT_B2] * x - smooth[ch][s*5+SLOT_A2] * y, 12),
                       DELAY_BITS, dummy);
            dly[ch][s][0] = n1;
            dly[ch][s][1] = n2;
            x = y;
          end
        end
        r.smp = x[23:0];
        r.ch = ch;
        r.clip = clip;
        expected_q.push_back(r);
      end
    endcase
  endfunction

  function void check_result(logic [23:0] smp, logic ch, logic clip);
    filt_result_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result smp=%h ch=%b clip=%b", $time, smp, ch, clip);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (smp !== e.smp) begin
      $display("%0t: out_sample exp %h got %h", $time, e.smp, smp);
      errors++;
    end
    if (ch !== e.ch) begin
      $display("%0t: out_channel exp %b got %b", $time, e.ch, ch);
      errors++;
    end
    if (clip !== e.clip) begin
      $display("%0t: clipped exp %b got %b", $time, e.clip, clip);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb;
  localparam int IDLE_LIMIT = 5000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [55:0] s_tdata = 0;
  logic [1:0]  s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  biquad_scoreboard sb = new();
  int  burst_left = 0;
  bit  hold_req = 0;
  int  quiet_cycles = 0;

  smoothed_biquad_cascade_top uut (.*);

  always #5 clk = ~clk;

  // result monitor and stall watchdog
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata[23:0], m_tdata[24], m_tuser[0]);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: runs of random ready density, one long hold-off on request
  initial begin
    int run_len, pct;
    forever begin
      run_len = $urandom_range(20, 300);
      case ($urandom_range(0, 2))
        0: pct = 100;
        1: pct = 50;
        default: pct = 10;
      endcase
      repeat (run_len) begin
        @(negedge clk);
        if (hold_req) begin
          m_tready = 0;
          repeat (600) @(negedge clk);
          hold_req = 0;
        end
        m_tready = ($urandom_range(1, 100) <= pct);
      end
    end
  end

  task automatic send_item(op_t op, logic ch, logic [4:0] idx, logic [23:0] smp,
                           logic [23:0] cv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        s_tvalid = 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tdata = {2'b00, cv, smp, idx, ch};
    s_tuser = op;
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, ch, idx, smp, cv);
    @(negedge clk);
  endtask

  // let every result drain and the last non-result request finish
  task automatic settle();
    s_tvalid = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] v);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 0;
    sb.write_reg(idx, v);
  endtask

  task automatic random_item();
    int pick;
    logic [23:0] cv;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1)) cv = 24'($urandom);
    else cv = 24'(int'($urandom_range(0, 1887436)) - 943718);
    if (pick < 60)
      send_item(OP_SAMPLE, 1'($urandom_range(0, 1)), 5'($urandom), 24'($urandom),
                24'($urandom));
    else if (pick < 82)
      send_item(OP_LOAD, 1'($urandom), ($urandom_range(0, 9) == 0)
                ? 5'($urandom_range(20, 31)) : 5'($urandom_range(0, 19)),
                24'($urandom), cv);
    else if (pick < 98)
      send_item(OP_STEP, 1'($urandom_range(0, 1)), 5'($urandom), 24'($urandom),
                24'($urandom));
    else send_item(OP_CLEAR, 1'($urandom), 5'($urandom), 24'($urandom), 24'($urandom));
  endtask

  initial begin
    logic [23:0] lp[5];
    lp = '{24'sd262144, 24'sd524288, 24'sd262144, -24'sd524288, 24'sd104858};
    repeat (4) @(negedge clk);
    rst = 0;

    // directed: passthrough extremes, a mild lowpass, clipping, ignored loads, clear
    send_item(OP_SAMPLE, 0, 0, 24'h7fffff, 0);
    send_item(OP_SAMPLE, 1, 0, 24'h800000, 0);
    for (int k = 0; k < 5; k++) send_item(OP_LOAD, 0, 5'(k), 0, lp[k]);
    send_item(OP_LOAD, 0, 20, 0, 24'h7fffff);
    send_item(OP_LOAD, 1, 31, 0, 24'h800000);
    repeat (3) send_item(OP_STEP, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 0, 0, 24'h7fffff, 0);
    send_item(OP_SAMPLE, 0, 0, 24'h800000, 0);
    send_item(OP_SAMPLE, 1, 0, 24'h400000, 0);
    send_item(OP_LOAD, 0, 15, 0, 24'h7fffff);
    send_item(OP_LOAD, 0, 16, 0, 24'h800000);
    send_item(OP_STEP, 1, 0, 0, 0);
    send_item(OP_SAMPLE, 1, 0, 24'h7fffff, 0);
    send_item(OP_SAMPLE, 1, 0, 24'h000001, 0);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 1, 0, 24'h123456, 0);
    settle();
    write_cfg(REG_ENABLE, 16'h0000);
    send_item(OP_SAMPLE, 0, 0, 24'h7fffff, 0);
    send_item(OP_STEP, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 1, 0, 24'h800000, 0);
    settle();
    write_cfg(REG_ENABLE, 16'hfffe);

    // random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin write_cfg(REG_ENABLE, 16'd1); write_cfg(REG_RATE, 16'hffff); end
        1: begin write_cfg(REG_ENABLE, 16'd1); write_cfg(REG_RATE, 16'h0000); end
        2: begin write_cfg(REG_ENABLE, 16'd0); write_cfg(REG_RATE, 16'($urandom)); end
        3: begin write_cfg(REG_ENABLE, 16'd1); write_cfg(REG_RATE, 16'd6554); end
        default: begin
          write_cfg(REG_ENABLE, 16'hffff);
          write_cfg(REG_RATE, 16'($urandom));
        end
      endcase
      if (ph == 3) hold_req = 1;
      repeat (400) random_item();
    end

    settle();
    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule

// ----- smoothed_biquad_cascade_top.f -----
+incdir+hdl
hdl/sbq_pkg.sv
hdl/sbq_cell.sv
hdl/smoothed_biquad_cascade_top.sv
bench/tb.sv
